[hdl/quad_lfo_phase_sync_network_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the quad LFO sync network
// Same-cycle and next-cycle implications with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef QUAD_LFO_PHASE_SYNC_NETWORK_ASSERT_SVH
`define QUAD_LFO_PHASE_SYNC_NETWORK_ASSERT_SVH

// label: antecedent implies consequent in the same cycle
`define QLFO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("qlfo assertion failed");

// label: antecedent implies consequent in the next cycle
`define QLFO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("qlfo assertion failed");

`endif

[hdl/qlfo_pkg.sv]
// ----------------------------------------------------------------------------
// qlfo_pkg
// Shared constants, register indexes, topology codes and types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qlfo_pkg;

	localparam int N_LFO         = 4;
	localparam int STEP_BITS     = 31;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 31;
	localparam int TOPO_BITS     = 3;
	localparam int PHASE_BITS_DEF = 32;
	localparam int OUT_BITS_DEF   = 16;

	localparam logic [STEP_BITS-1:0] STEP_RESET = 31'd194783;

	localparam logic [CFG_IDX_BITS-1:0] REG_STEP1  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_STEP2  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_STEP3  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_STEP4  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_TOPO   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_SOFT   = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_INVERT = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_USED   = 3'd7;

	typedef enum logic [TOPO_BITS-1:0] {
		TOPO_OFF     = 3'd0,
		TOPO_2TO1    = 3'd1,
		TOPO_4TO3    = 3'd2,
		TOPO_BOTH    = 3'd3,
		TOPO_234TO1  = 3'd4,
		TOPO_34TO12  = 3'd5,
		TOPO_4TO123  = 3'd6
	} topo_t;

	typedef struct packed {
		logic [N_LFO-1:0][STEP_BITS-1:0] step;
		logic [TOPO_BITS-1:0]            topo;
		logic                            soft_sync;
		logic [N_LFO-1:0]                inv;
		logic [N_LFO-1:0]                used;
	} cfg_t;

	typedef struct packed {
		logic [N_LFO-1:0] active;
		logic [N_LFO-1:0] wraps;
		logic [N_LFO-1:0] synced;
	} sync_res_t;

	typedef struct packed {
		logic adv;
		logic sync;
		logic soft_sync;
		logic dir_clr;
		logic inv;
	} lane_ctl_t;

endpackage

[hdl/qlfo_intf.sv]
// ----------------------------------------------------------------------------
// qlfo channel interfaces
// Valid/ready channels for ticks, results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface qlfo_in_if;
	logic valid;
	logic ready;
	logic advance;

	modport source (output valid, output advance, input ready);
	modport sink (input valid, input advance, output ready);
endinterface

interface qlfo_out_if #(
	parameter int OUT_BITS = 16
);
	logic                valid;
	logic                ready;
	logic [OUT_BITS-1:0] saw_1;
	logic [OUT_BITS-1:0] saw_2;
	logic [OUT_BITS-1:0] saw_3;
	logic [OUT_BITS-1:0] saw_4;
	logic [3:0]          wrap_mask;
	logic [3:0]          sync_mask;

	modport source (output valid, output saw_1, output saw_2, output saw_3, output saw_4,
		output wrap_mask, output sync_mask, input ready);
	modport sink (input valid, input saw_1, input saw_2, input saw_3, input saw_4,
		input wrap_mask, input sync_mask, output ready);
endinterface

interface qlfo_cfg_if;
	import qlfo_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/qlfo_cfg.sv]
// ----------------------------------------------------------------------------
// qlfo_cfg
// Register file; flags direction clears when the sync mode changes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qlfo_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	qlfo_cfg_if.sink                     cfg,
	output qlfo_pkg::cfg_t               regs,
	output logic [qlfo_pkg::N_LFO-1:0]   dir_clr
);
	import qlfo_pkg::*;

	cfg_t regs_q;
	logic wr;
	logic soft_new;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid;
	assign soft_new  = cfg.data[0];
	assign regs      = regs_q;

	always_comb begin
		dir_clr = '0;
		if (wr && cfg.index == REG_SOFT && soft_new != regs_q.soft_sync) begin
			if (!soft_new) begin
				dir_clr = 4'b1110;
			end else begin
				dir_clr[1] = (regs_q.topo == TOPO_OFF) || (regs_q.topo == TOPO_4TO3);
				dir_clr[2] = (regs_q.topo != TOPO_234TO1);
				dir_clr[3] = (regs_q.topo != TOPO_OFF) && (regs_q.topo != TOPO_2TO1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.step      <= {N_LFO{STEP_RESET}};
			regs_q.topo      <= TOPO_OFF;
			regs_q.soft_sync <= 1'b0;
			regs_q.inv       <= '0;
			regs_q.used      <= '0;
		end else if (wr) begin
			unique case (cfg.index)
				REG_STEP1:  regs_q.step[0] <= cfg.data[STEP_BITS-1:0];
				REG_STEP2:  regs_q.step[1] <= cfg.data[STEP_BITS-1:0];
				REG_STEP3:  regs_q.step[2] <= cfg.data[STEP_BITS-1:0];
				REG_STEP4:  regs_q.step[3] <= cfg.data[STEP_BITS-1:0];
				REG_TOPO:   regs_q.topo <= cfg.data[TOPO_BITS-1:0];
				REG_SOFT:   regs_q.soft_sync <= soft_new;
				REG_INVERT: regs_q.inv  <= cfg.data[N_LFO-1:0];
				REG_USED:   regs_q.used <= cfg.data[N_LFO-1:0];
				default:    ;
			endcase
		end
	end

endmodule

[hdl/qlfo_sync.sv]
// ----------------------------------------------------------------------------
// qlfo_sync
// Master widening, wrap gating and sync request routing per topology.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qlfo_sync (
	input  logic [qlfo_pkg::TOPO_BITS-1:0] topo,
	input  logic [qlfo_pkg::N_LFO-1:0]     used,
	input  logic                           act,
	input  logic [qlfo_pkg::N_LFO-1:0]     wrap_raw,
	output qlfo_pkg::sync_res_t            res
);
	import qlfo_pkg::*;

	logic [N_LFO-1:0] u;
	logic [N_LFO-1:0] w;
	logic [N_LFO-1:0] req;

	always_comb begin
		u = used;
		unique case (topo_t'(topo))
			TOPO_2TO1:   if (used[1]) u[0] = 1'b1;
			TOPO_4TO3:   if (used[3]) u[2] = 1'b1;
			TOPO_BOTH: begin
				if (used[1]) u[0] = 1'b1;
				if (used[3]) u[2] = 1'b1;
			end
			TOPO_234TO1: if (|used[3:1]) u[0] = 1'b1;
			TOPO_34TO12: if (|used[3:2]) u[1:0] = 2'b11;
			TOPO_4TO123: if (used[3]) u[2:0] = 3'b111;
			default:     ;
		endcase
		if (!act) u = '0;
	end

	assign w = wrap_raw & u;

	always_comb begin
		req    = '0;
		req[1] = w[0] && (topo == TOPO_2TO1 || topo == TOPO_BOTH || topo == TOPO_234TO1);
		req[2] = (w[0] && (topo == TOPO_234TO1 || topo == TOPO_34TO12))
			|| (w[1] && topo == TOPO_34TO12);
		req[3] = (w[0] && (topo == TOPO_234TO1 || topo == TOPO_34TO12))
			|| (w[1] && topo == TOPO_34TO12)
			|| (w[2] && (topo == TOPO_4TO3 || topo == TOPO_BOTH))
			|| ((|w[2:0]) && topo == TOPO_4TO123);
	end

	assign res.active = u;
	assign res.wraps  = w;
	assign res.synced = req & u;

endmodule

[hdl/qlfo_lane.sv]
// ----------------------------------------------------------------------------
// qlfo_lane
// One phase accumulator with direction, sync handling and saw output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qlfo_lane #(
	parameter int PHASE_BITS = qlfo_pkg::PHASE_BITS_DEF,
	parameter int OUT_BITS   = qlfo_pkg::OUT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [qlfo_pkg::STEP_BITS-1:0]    step,
	input  qlfo_pkg::lane_ctl_t               ctl,
	output logic [OUT_BITS-1:0]               saw,
	output logic                              wrap
);
	import qlfo_pkg::*;

	localparam int SW = ((PHASE_BITS > STEP_BITS) ? PHASE_BITS : STEP_BITS) + 1;

	logic [PHASE_BITS-1:0] phase_q;
	logic                  dir_neg_q;
	logic [SW-1:0]         p_ext;
	logic [SW-1:0]         s_ext;
	logic [SW-1:0]         sum;
	logic [SW-1:0]         dif;
	logic [PHASE_BITS-1:0] next_phase;
	logic [PHASE_BITS:0]   down;
	logic [PHASE_BITS-1:0] sel;
	logic                  sat;
	logic [OUT_BITS-1:0]   scaled;

	assign p_ext = SW'(phase_q);
	assign s_ext = SW'(step);
	assign sum   = p_ext + s_ext;
	assign dif   = p_ext - s_ext;

	always_comb begin
		if (dir_neg_q) begin
			wrap       = s_ext > p_ext;
			next_phase = dif[PHASE_BITS-1:0];
		end else begin
			wrap       = |sum[SW-1:PHASE_BITS];
			next_phase = sum[PHASE_BITS-1:0];
		end
	end

	assign down = {1'b1, {PHASE_BITS{1'b0}}} - {1'b0, phase_q};
	assign sel  = ctl.inv ? phase_q : down[PHASE_BITS-1:0];
	assign sat  = !ctl.inv && down[PHASE_BITS];

	generate
		if (PHASE_BITS >= OUT_BITS) begin : g_scale_dn
			assign scaled = sel[PHASE_BITS-1 -: OUT_BITS];
		end else begin : g_scale_up
			assign scaled = {sel, {(OUT_BITS - PHASE_BITS){1'b0}}};
		end
	endgenerate

	assign saw = sat ? {OUT_BITS{1'b1}} : scaled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			dir_neg_q <= 1'b0;
		end else begin
			if (ctl.adv) begin
				phase_q <= (ctl.sync && !ctl.soft_sync) ? '0 : next_phase;
			end
			if (ctl.dir_clr) begin
				dir_neg_q <= 1'b0;
			end else if (ctl.adv && ctl.sync && ctl.soft_sync) begin
				dir_neg_q <= !dir_neg_q;
			end
		end
	end

endmodule

[hdl/quad_lfo_phase_sync_network.sv]
// ----------------------------------------------------------------------------
// quad_lfo_phase_sync_network
// Four synced phase-accumulator LFOs, one tick per accepted transaction.
// Output: the result is registered from the accepted tick transaction.
// Throughput: one tick per cycle unless a held result stalls; an adder and a
// subtractor per LFO and the sync routing sit between phase and result regs.
// Reset: phases zero, directions positive, registers at defaults, no result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quad_lfo_phase_sync_network #(
	parameter int PHASE_BITS = qlfo_pkg::PHASE_BITS_DEF,
	parameter int OUT_BITS   = qlfo_pkg::OUT_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	qlfo_in_if.sink      din,
	qlfo_out_if.source   dout,
	qlfo_cfg_if.sink     cfg
);
	import qlfo_pkg::*;

	cfg_t                         regs;
	logic [N_LFO-1:0]             dir_clr;
	logic                         in_fire;
	logic                         act;
	logic [N_LFO-1:0]             wrap_raw;
	sync_res_t                    sres;
	lane_ctl_t [N_LFO-1:0]        ctl;
	logic [N_LFO-1:0][OUT_BITS-1:0] saw;

	logic                         out_valid_q;
	logic [N_LFO-1:0][OUT_BITS-1:0] saw_q;
	logic [N_LFO-1:0]             wrap_q;
	logic [N_LFO-1:0]             sync_q;

	assign din.ready = !out_valid_q || dout.ready;
	assign in_fire   = din.valid && din.ready;
	assign act       = in_fire && din.advance;

	qlfo_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.regs    (regs),
		.dir_clr (dir_clr)
	);

	qlfo_sync u_sync (
		.topo     (regs.topo),
		.used     (regs.used),
		.act      (act),
		.wrap_raw (wrap_raw),
		.res      (sres)
	);

	generate
		for (genvar i = 0; i < N_LFO; i++) begin : g_lane
			assign ctl[i].adv       = sres.active[i];
			assign ctl[i].sync      = sres.synced[i];
			assign ctl[i].soft_sync = regs.soft_sync;
			assign ctl[i].dir_clr   = dir_clr[i];
			assign ctl[i].inv       = regs.inv[i];

			qlfo_lane #(
				.PHASE_BITS (PHASE_BITS),
				.OUT_BITS   (OUT_BITS)
			) u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.step   (regs.step[i]),
				.ctl    (ctl[i]),
				.saw    (saw[i]),
				.wrap   (wrap_raw[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (din.ready) begin
			out_valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			saw_q  <= saw;
			wrap_q <= sres.wraps;
			sync_q <= sres.synced;
		end
	end

	assign dout.valid     = out_valid_q;
	assign dout.saw_1     = saw_q[0];
	assign dout.saw_2     = saw_q[1];
	assign dout.saw_3     = saw_q[2];
	assign dout.saw_4     = saw_q[3];
	assign dout.wrap_mask = wrap_q;
	assign dout.sync_mask = sync_q;

endmodule

[hdl/qlfo_chk.sv]
// ----------------------------------------------------------------------------
// qlfo_chk
// Port-level checks on the tick and result channels, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quad_lfo_phase_sync_network_assert.svh"

module qlfo_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] wrap_mask,
	input logic [3:0] sync_mask
);

	`QLFO_ASSERT_NOW(a_lfo1_never_synced, clk, arst_n, out_valid, !sync_mask[0])
	`QLFO_ASSERT_NOW(a_sync_needs_wrap, clk, arst_n, out_valid && (sync_mask != 4'b0000), wrap_mask != 4'b0000)
	`QLFO_ASSERT_NEXT(a_tick_gives_result, clk, arst_n, in_valid && in_ready, out_valid)
	`QLFO_ASSERT_NEXT(a_stall_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(wrap_mask) && $stable(sync_mask))

endmodule

bind quad_lfo_phase_sync_network qlfo_chk u_qlfo_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.wrap_mask (dout.wrap_mask),
	.sync_mask (dout.sync_mask)
);
